// ===== sv/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared constants, types and the digit decode for the hex record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

   // record buffer geometry
   localparam int MAX_RECORD_BYTES = 32;
   localparam int IDX_W            = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int NWR_W            = $clog2(MAX_RECORD_BYTES + 1);

   // line queue: one buffer bank per queued line
   localparam int QPTR_W      = 1;
   localparam int QUEUE_DEPTH = 2 ** QPTR_W;
   localparam int MEM_AW      = QPTR_W + IDX_W;
   localparam int MEM_DEPTH   = 2 ** MEM_AW;

   // character position counter
   localparam int            POS_W   = 11;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int            LEN_W   = POS_W + 1;
   localparam int            K_W     = POS_W - 1;

   // decoded pair: 16 * digit + digit with digits in -96..31
   localparam int PAIR_W = 12;
   localparam int NEED_W = PAIR_W + 2;
   localparam logic [LEN_W-1:0]         MIN_LINE  = LEN_W'(11);
   localparam logic signed [PAIR_W-1:0] MAX_COUNT = PAIR_W'(MAX_RECORD_BYTES);

   // fixed positions of the header pairs
   localparam logic [POS_W-1:0] POS_COUNT   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_ADDR_HI = POS_W'(4);
   localparam logic [POS_W-1:0] POS_ADDR_LO = POS_W'(6);
   localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(8);
   localparam logic [POS_W-1:0] POS_DATA    = POS_W'(10);

   // record types
   localparam logic signed [PAIR_W-1:0] REC_DATA = PAIR_W'(0);
   localparam logic signed [PAIR_W-1:0] REC_EOF  = PAIR_W'(1);
   localparam logic signed [PAIR_W-1:0] REC_ELA  = PAIR_W'(4);

   // result kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_LENGTH   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_CHECKSUM = 3'd4,
      ST_TYPE     = 3'd5
   } status_type;

   // one judged line waiting for the back end
   typedef struct packed {
      logic [15:0]      base;
      logic [NWR_W-1:0] nwr;
      status_type       status;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WRITE,
      BK_STATUS
   } back_state_type;

   // hex digit decode, signed result in -96..31
   function automatic logic signed [7:0] digit_of(input logic [7:0] code);
      logic signed [7:0] s;
      logic signed [7:0] v;
      s = signed'(code);
      if (s > 8'sd57) v = s - 8'sd87;
      else            v = s - 8'sd48;
      if (v < 8'sd0)       digit_of = v + 8'sd32;
      else if (v > 8'sd15) digit_of = 8'sd15;
      else                 digit_of = v;
   endfunction

endpackage

// ===== sv/ihex_if.sv =====
// ----------------------------------------------------------------------------
// ihex_req_if / ihex_rsp_if
// Valid/ready channels for line characters and loader results.
// ----------------------------------------------------------------------------
interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [2:0]  record_status;
   logic        last_result;

   modport source (output valid, output result_kind, output write_address,
                   output write_data, output record_status, output last_result,
                   input ready);
   modport sink   (input valid, input result_kind, input write_address,
                   input write_data, input record_status, input last_result,
                   output ready);
endinterface

// ===== sv/ihex_queue.sv =====
// ----------------------------------------------------------------------------
// ihex_queue
// Queue of judged lines with one data byte bank per queue slot.
// ----------------------------------------------------------------------------
module ihex_queue (
   input  logic                    clock,
   input  logic                    reset,
   // front side
   input  logic                    push,
   input  ihex_pkg::job_type       push_job,
   output logic                    full,
   input  logic                    buf_we,
   input  logic [ihex_pkg::IDX_W-1:0] buf_widx,
   input  logic [7:0]              buf_wdata,
   // back side
   input  logic                    pop,
   output ihex_pkg::job_type       head_job,
   output logic                    job_valid,
   input  logic                    buf_re,
   input  logic [ihex_pkg::IDX_W-1:0] buf_ridx,
   output logic [7:0]              buf_rdata
);
   import ihex_pkg::*;

   logic [7:0]        data_mem [MEM_DEPTH];
   job_type           job_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic [7:0]        rdata_ff;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign job_valid = (cnt_ff != '0);
   assign head_job  = job_ff[head_ff];
   assign buf_rdata = rdata_ff;

   // pointer and fill count update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push) tail_in = tail_ff + 1'b1;
      if (pop)  head_in = head_ff + 1'b1;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   // job slots
   always_ff @(posedge clock) begin
      if (push) job_ff[tail_ff] <= push_job;
   end

   // byte banks: the front fills the tail bank, the back reads the head bank
   always_ff @(posedge clock) begin
      if (buf_we) data_mem[{tail_ff, buf_widx}] <= buf_wdata;
      if (buf_re) rdata_ff <= data_mem[{head_ff, buf_ridx}];
   end

endmodule

// ===== sv/ihex_front.sv =====
// ----------------------------------------------------------------------------
// ihex_front
// Character decoder: pairs digits into fields, buffers data bytes and
// judges the line at its end.
// ----------------------------------------------------------------------------
module ihex_front (
   input  logic                       clock,
   input  logic                       reset,
   ihex_req_if.sink                   req,
   input  logic                       q_full,
   output logic                       push,
   output ihex_pkg::job_type          push_job,
   output logic                       buf_we,
   output logic [ihex_pkg::IDX_W-1:0] buf_widx,
   output logic [7:0]                 buf_wdata
);
   import ihex_pkg::*;

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [PAIR_W-1:0] count_ff, count_in;
   logic [15:0]              addr_ff, addr_in;
   logic signed [PAIR_W-1:0] kind_ff, kind_in;
   logic signed [7:0]        pend_ff, pend_in;
   logic [7:0]               sum_ff, sum_in;
   logic [7:0]               csum_ff, csum_in;

   logic                     accept;
   logic signed [7:0]        dv;
   logic signed [PAIR_W-1:0] pv;
   logic [POS_W-1:0]         koff;
   logic [K_W-1:0]           k;
   logic signed [PAIR_W-1:0] k_s;
   logic [LEN_W-1:0]         len;
   logic signed [NEED_W-1:0] need;
   logic signed [NEED_W-1:0] len_s;
   logic [7:0]               sum8;

   assign accept    = req.valid && req.ready;
   assign req.ready = !q_full;

   // field decode and line judgement
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      kind_in  = kind_ff;
      pend_in  = pend_ff;
      sum_in   = sum_ff;
      csum_in  = csum_ff;
      buf_we   = 1'b0;
      push     = 1'b0;
      push_job = '{base: addr_ff, nwr: '0, status: ST_OK};

      dv   = digit_of(req.char_code);
      pv   = {pend_ff, 4'b0000} + PAIR_W'(dv);
      koff = pos_ff - POS_DATA;
      k    = koff[POS_W-1:1];
      k_s  = signed'(PAIR_W'(k));
      buf_widx  = k[IDX_W-1:0];
      buf_wdata = pv[7:0];

      if (accept) begin
         if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;
         if (pos_ff != '0) begin
            if (pos_ff[0]) begin
               pend_in = dv;
            end else if (pos_ff == POS_COUNT) begin
               count_in = pv;
            end else if (pos_ff == POS_ADDR_HI) begin
               addr_in = {pv[7:0], 8'h00};
            end else if (pos_ff == POS_ADDR_LO) begin
               addr_in = addr_ff + 16'(pv);
            end else if (pos_ff == POS_TYPE) begin
               kind_in = pv;
            end else if (pos_ff >= POS_DATA) begin
               if (k_s < count_ff) begin
                  buf_we = (k < K_W'(MAX_RECORD_BYTES));
                  sum_in = sum_ff + pv[7:0];
               end else if (k_s == count_ff) begin
                  csum_in = pv[7:0];
               end
            end
         end
      end

      // judgement on the values including this character
      len   = LEN_W'(pos_ff) + 1'b1;
      len_s = signed'(NEED_W'(len));
      need  = NEED_W'(11) + (NEED_W'(count_in) <<< 1);
      sum8  = count_in[7:0] + addr_in[15:8] + addr_in[7:0] + kind_in[7:0]
            + sum_in + csum_in;

      if (accept && req.line_end) begin
         push          = 1'b1;
         push_job.base = addr_in;
         if (len < MIN_LINE) begin
            push_job.status = ST_SHORT;
         end else if (len_s != need) begin
            push_job.status = ST_LENGTH;
         end else if (count_in > MAX_COUNT) begin
            push_job.status = ST_OVERFLOW;
         end else if (sum8 != 8'h00) begin
            push_job.status = ST_CHECKSUM;
         end else if (kind_in == REC_DATA) begin
            push_job.status = ST_OK;
            push_job.nwr    = count_in[NWR_W-1:0];
         end else if (kind_in == REC_EOF || kind_in == REC_ELA) begin
            push_job.status = ST_OK;
         end else begin
            push_job.status = ST_TYPE;
         end
         // start the next line from a clean state
         pos_in   = '0;
         count_in = '0;
         addr_in  = '0;
         kind_in  = '0;
         pend_in  = '0;
         sum_in   = '0;
         csum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         addr_ff  <= '0;
         kind_ff  <= '0;
         pend_ff  <= '0;
         sum_ff   <= '0;
         csum_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         kind_ff  <= kind_in;
         pend_ff  <= pend_in;
         sum_ff   <= sum_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

// ===== sv/ihex_back.sv =====
// ----------------------------------------------------------------------------
// ihex_back
// Result sequencer: replays the buffered bytes of a good data record as
// memory writes, then closes the line with its status.
// ----------------------------------------------------------------------------
module ihex_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  ihex_pkg::job_type          head_job,
   output logic                       pop,
   output logic                       buf_re,
   output logic [ihex_pkg::IDX_W-1:0] buf_ridx,
   input  logic [7:0]                 buf_rdata,
   ihex_rsp_if.source                 rsp
);
   import ihex_pkg::*;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_acc;
   logic             last_byte;

   assign out_acc   = rsp.valid && rsp.ready;
   assign last_byte = ((NWR_W'(idx_ff) + 1'b1) == head_job.nwr);
   assign buf_ridx  = idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            idx_in = '0;
            if (job_valid) begin
               if (head_job.nwr != '0) state_in = BK_READ;
               else                    state_in = BK_STATUS;
            end
         end
         BK_READ: begin
            state_in = BK_WRITE;
         end
         BK_WRITE: begin
            if (out_acc) begin
               if (last_byte) begin
                  state_in = BK_STATUS;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_STATUS: begin
            if (out_acc) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      buf_re            = 1'b0;
      pop               = 1'b0;
      rsp.valid         = 1'b0;
      rsp.result_kind   = KIND_WRITE;
      rsp.write_address = '0;
      rsp.write_data    = '0;
      rsp.record_status = ST_OK;
      rsp.last_result   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
         end
         BK_READ: begin
            buf_re = 1'b1;
         end
         BK_WRITE: begin
            rsp.valid         = 1'b1;
            rsp.write_address = head_job.base + 16'(idx_ff);
            rsp.write_data    = buf_rdata;
         end
         BK_STATUS: begin
            rsp.valid         = 1'b1;
            rsp.result_kind   = KIND_STATUS;
            rsp.record_status = head_job.status;
            rsp.last_result   = 1'b1;
            pop               = rsp.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== sv/intel_hex_record_loader.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Parses hex record lines one character at a time and issues memory writes
// and one status result per line.
// ----------------------------------------------------------------------------
// The front decoder takes one character per cycle as long as the line queue
// has room; a line end judges the record in that same cycle and hands it to
// a two-entry queue, each entry with its own 32-byte bank, so the next line
// is parsed while the back end drains the previous one. The back end issues
// each memory write as a bank read followed by the result, and then the
// closing status; the front stalls only while two judged lines are still
// unfinished. No clearing pass is needed after reset.
module intel_hex_record_loader (
   input  logic       clock,
   input  logic       reset,
   ihex_req_if.sink   req_if,
   ihex_rsp_if.source rsp_if
);
   import ihex_pkg::*;

   logic             push;
   job_type          push_job;
   logic             q_full;
   logic             buf_we;
   logic [IDX_W-1:0] buf_widx;
   logic [7:0]       buf_wdata;
   logic             pop;
   job_type          head_job;
   logic             job_valid;
   logic             buf_re;
   logic [IDX_W-1:0] buf_ridx;
   logic [7:0]       buf_rdata;

   // character decoder
   ihex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job),
      .buf_we    (buf_we),
      .buf_widx  (buf_widx),
      .buf_wdata (buf_wdata)
   );

   // judged line queue with byte banks
   ihex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .buf_we    (buf_we),
      .buf_widx  (buf_widx),
      .buf_wdata (buf_wdata),
      .pop       (pop),
      .head_job  (head_job),
      .job_valid (job_valid),
      .buf_re    (buf_re),
      .buf_ridx  (buf_ridx),
      .buf_rdata (buf_rdata)
   );

   // result sequencer
   ihex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .head_job  (head_job),
      .pop       (pop),
      .buf_re    (buf_re),
      .buf_ridx  (buf_ridx),
      .buf_rdata (buf_rdata),
      .rsp       (rsp_if)
   );

endmodule
